### design/vts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume trilinear sampler package
// Shared widths, field positions and codes for the sampler and its voxel RAM.
// ----------------------------------------------------------------------------
package vts_pkg;

	localparam int MAX_DIM    = 32;
	localparam int DIM_BITS   = $clog2(MAX_DIM);
	localparam int SIZE_BITS  = DIM_BITS + 1;
	localparam int FRAC_BITS  = 8;
	localparam int VALUE_BITS = 16;
	localparam int COORD_BITS = DIM_BITS + FRAC_BITS;
	localparam int ADDR_BITS  = 3 * DIM_BITS;

	// Weights along one axis run from 0 to 1.0 inclusive.
	localparam int W_BITS    = FRAC_BITS + 1;
	localparam int WXY_BITS  = 2 * FRAC_BITS + 1;
	localparam int W3_BITS   = 3 * FRAC_BITS + 1;
	localparam int PROD_BITS = VALUE_BITS + W3_BITS + 1;
	localparam int ACC_BITS  = PROD_BITS + 3;

	localparam logic [W_BITS-1:0]    FONE     = W_BITS'(1) << FRAC_BITS;
	localparam logic [SIZE_BITS-1:0] SIZE_MAX = SIZE_BITS'(MAX_DIM);
	localparam int XY_BITS = 2 * DIM_BITS + 1;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_X_SIZE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_Y_SIZE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_Z_SIZE = 2'd2;

	// Operation carried in the input tuser.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Input tdata layout.
	localparam int IN_IDX_LSB = 0;
	localparam int IN_VAL_LSB = IN_IDX_LSB + ADDR_BITS;
	localparam int IN_PX_LSB  = IN_VAL_LSB + VALUE_BITS;
	localparam int IN_PY_LSB  = IN_PX_LSB + COORD_BITS;
	localparam int IN_PZ_LSB  = IN_PY_LSB + COORD_BITS;
	localparam int IN_RAW     = IN_PZ_LSB + COORD_BITS;
	localparam int IN_TDATA_BITS  = ((IN_RAW + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic edge_fallback;
		logic out_of_range;
	} flags_t;

endpackage

### design/volume_trilinear_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume trilinear sampler
// Loads a voxel volume through write transfers and samples it at fixed-point
// points with exact trilinear interpolation and edge handling.
// ----------------------------------------------------------------------------
// A write transfer stores one voxel and gives no result. A sample whose
// corner is outside the volume loads the result register at the accepting
// edge, so the result is offered in the following cycle. A sample near the
// far faces reads only the corner voxel. An interior sample reads its eight
// neighbours, one per cycle through the single port of the voxel RAM, then
// drains a weight/multiply/accumulate pipeline. The input is held off while
// a sample is in progress and while an unaccepted result waits in the output
// register. The voxel RAM holds no defined contents until written.
module volume_trilinear_sampler (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Configuration write port.
	input  logic                                    cfg_we,
	input  logic [vts_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [vts_pkg::SIZE_BITS-1:0]           cfg_data,
	// Input stream.
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// tdata, from bit 0: voxel_index, voxel_value, point_x, point_y, point_z, zero fill
	input  logic [vts_pkg::IN_TDATA_BITS-1:0]       s_tdata,
	// tuser: op
	input  logic [0:0]                              s_tuser,
	// Output stream.
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// tdata: sample
	output logic [vts_pkg::OUT_TDATA_BITS-1:0]      m_tdata,
	// tuser, from bit 0: edge_fallback, out_of_range
	output logic [1:0]                              m_tuser
);

	localparam int DB = vts_pkg::DIM_BITS;
	localparam int FB = vts_pkg::FRAC_BITS;
	localparam int SB = vts_pkg::SIZE_BITS;
	localparam int AB = vts_pkg::ADDR_BITS;
	localparam int VB = vts_pkg::VALUE_BITS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ADDR  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0] state_q;

	logic [SB-1:0] x_size_q, y_size_q, z_size_q;
	logic [SB-1:0] xs, ys, zs;
	logic [vts_pkg::XY_BITS-1:0] xsys_q;

	logic [DB-1:0] cx_q, cy_q, cz_q;
	logic [FB-1:0] fx_q, fy_q, fz_q;
	logic          fb_q;
	logic [AB-1:0] a0_q;
	logic [2:0]    k_q;

	// Input fields.
	logic          in_op;
	logic [AB-1:0] in_index;
	logic [VB-1:0] in_value;
	logic [vts_pkg::COORD_BITS-1:0] in_px, in_py, in_pz;
	logic [DB-1:0] in_cx, in_cy, in_cz;
	logic          in_accept, corner_out, near_edge;

	// RAM port.
	logic          ram_we;
	logic [AB-1:0] ram_addr, rd_addr;
	logic [VB-1:0] ram_rdata;

	// Pipeline.
	logic issue;
	logic last_issue;
	logic [vts_pkg::W_BITS-1:0] wx, wy, wz;
	logic vld_s1, last_s1, vld_s2, last_s2, vld_s3, last_s3;
	logic [vts_pkg::WXY_BITS-1:0] wxy_s1;
	logic [vts_pkg::W_BITS-1:0]   wz_s1;
	logic [vts_pkg::W3_BITS-1:0]  w_s2;
	logic signed [VB-1:0]         v_s2;
	logic signed [vts_pkg::PROD_BITS-1:0] prod_s3;
	logic signed [vts_pkg::ACC_BITS-1:0]  acc_q;
	logic fin_q;
	logic [VB-1:0] result;

	// Output register.
	logic                 m_valid_q;
	logic [VB-1:0]        sample_q;
	vts_pkg::flags_t      flags_q;

	// Sizes above the store dimension saturate.
	assign xs = (x_size_q > vts_pkg::SIZE_MAX) ? vts_pkg::SIZE_MAX : x_size_q;
	assign ys = (y_size_q > vts_pkg::SIZE_MAX) ? vts_pkg::SIZE_MAX : y_size_q;
	assign zs = (z_size_q > vts_pkg::SIZE_MAX) ? vts_pkg::SIZE_MAX : z_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_size_q <= vts_pkg::SIZE_MAX;
			y_size_q <= vts_pkg::SIZE_MAX;
			z_size_q <= vts_pkg::SIZE_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vts_pkg::REG_X_SIZE: x_size_q <= cfg_data;
				vts_pkg::REG_Y_SIZE: y_size_q <= cfg_data;
				vts_pkg::REG_Z_SIZE: z_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Plane stride, refreshed every cycle from the size registers.
	always_ff @(posedge clk) begin
		xsys_q <= vts_pkg::XY_BITS'(xs) * vts_pkg::XY_BITS'(ys);
	end

	assign in_op    = s_tuser[0];
	assign in_index = s_tdata[vts_pkg::IN_IDX_LSB +: AB];
	assign in_value = s_tdata[vts_pkg::IN_VAL_LSB +: VB];
	assign in_px    = s_tdata[vts_pkg::IN_PX_LSB +: vts_pkg::COORD_BITS];
	assign in_py    = s_tdata[vts_pkg::IN_PY_LSB +: vts_pkg::COORD_BITS];
	assign in_pz    = s_tdata[vts_pkg::IN_PZ_LSB +: vts_pkg::COORD_BITS];
	assign in_cx    = in_px[FB +: DB];
	assign in_cy    = in_py[FB +: DB];
	assign in_cz    = in_pz[FB +: DB];

	assign corner_out = ({1'b0, in_cx} >= xs) || ({1'b0, in_cy} >= ys) ||
	                    ({1'b0, in_cz} >= zs);
	assign near_edge  = ({1'b0, in_cx} + SB'(1) >= xs) ||
	                    ({1'b0, in_cy} + SB'(1) >= ys) ||
	                    ({1'b0, in_cz} + SB'(1) >= zs);

	assign s_tready  = (state_q == ST_IDLE) && (!m_valid_q || m_tready);
	assign in_accept = s_tvalid && s_tready;

	// Neighbour k sits at +1 along x, y and z for bits 0, 1 and 2 of k.
	assign rd_addr = a0_q + AB'(k_q[0]) + (k_q[1] ? AB'(xs) : AB'(0)) +
	                 (k_q[2] ? AB'(xsys_q) : AB'(0));

	assign ram_we   = in_accept && (in_op == vts_pkg::OP_WRITE);
	assign ram_addr = ram_we ? in_index : rd_addr;

	vts_voxel_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (in_value),
		.rdata (ram_rdata)
	);

	assign issue      = (state_q == ST_READ);
	assign last_issue = issue && (fb_q || (k_q == 3'd7));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			fb_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && (in_op == vts_pkg::OP_SAMPLE) && !corner_out) begin
						fb_q    <= near_edge;
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					k_q     <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					k_q <= k_q + 3'd1;
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (fin_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Query payload. A fallback query uses zero fractions so that the corner
	// voxel carries the full weight.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cx_q <= in_cx;
			cy_q <= in_cy;
			cz_q <= in_cz;
			fx_q <= near_edge ? '0 : in_px[FB-1:0];
			fy_q <= near_edge ? '0 : in_py[FB-1:0];
			fz_q <= near_edge ? '0 : in_pz[FB-1:0];
		end
		if (state_q == ST_ADDR) begin
			a0_q <= AB'(cx_q) + AB'(cy_q) * AB'(xs) + AB'(cz_q) * AB'(xsys_q);
		end
	end

	assign wx = k_q[0] ? {1'b0, fx_q} : (vts_pkg::FONE - {1'b0, fx_q});
	assign wy = k_q[1] ? {1'b0, fy_q} : (vts_pkg::FONE - {1'b0, fy_q});
	assign wz = k_q[2] ? {1'b0, fz_q} : (vts_pkg::FONE - {1'b0, fz_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			vld_s3  <= 1'b0;
			last_s3 <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			vld_s1  <= issue;
			last_s1 <= last_issue;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			vld_s3  <= vld_s2;
			last_s3 <= last_s2;
			fin_q   <= vld_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		wxy_s1  <= vts_pkg::WXY_BITS'(wx) * vts_pkg::WXY_BITS'(wy);
		wz_s1   <= wz;
		w_s2    <= vts_pkg::W3_BITS'(wxy_s1) * vts_pkg::W3_BITS'(wz_s1);
		v_s2    <= $signed(ram_rdata);
		prod_s3 <= v_s2 * $signed({1'b0, w_s2});
		if (state_q == ST_ADDR) begin
			acc_q <= '0;
		end else if (vld_s3) begin
			acc_q <= acc_q + vts_pkg::ACC_BITS'(prod_s3);
		end
	end

	// Weights sum to one, so the scaled total truncated toward zero fits.
	always_comb begin
		result = acc_q[3*FB +: VB];
		if (acc_q[vts_pkg::ACC_BITS-1] && (acc_q[3*FB-1:0] != '0)) begin
			result = acc_q[3*FB +: VB] + VB'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fin_q) begin
			m_valid_q <= 1'b1;
		end else if (in_accept && (in_op == vts_pkg::OP_SAMPLE) && corner_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q) begin
			sample_q              <= result;
			flags_q.edge_fallback <= fb_q;
			flags_q.out_of_range  <= 1'b0;
		end else if (in_accept && (in_op == vts_pkg::OP_SAMPLE) && corner_out) begin
			sample_q              <= '0;
			flags_q.edge_fallback <= 1'b0;
			flags_q.out_of_range  <= 1'b1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = vts_pkg::OUT_TDATA_BITS'(sample_q);
	assign m_tuser  = {flags_q.out_of_range, flags_q.edge_fallback};

endmodule

### design/vts_voxel_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel RAM
// Single-port synchronous store of voxel intensities, registered read data.
// ----------------------------------------------------------------------------
module vts_voxel_ram (
	input  logic                             clk,
	input  logic                             we,
	input  logic [vts_pkg::ADDR_BITS-1:0]    addr,
	input  logic [vts_pkg::VALUE_BITS-1:0]   wdata,
	output logic [vts_pkg::VALUE_BITS-1:0]   rdata
);

	localparam int DEPTH = 1 << vts_pkg::ADDR_BITS;

	logic [vts_pkg::VALUE_BITS-1:0] mem [DEPTH];
	logic [vts_pkg::VALUE_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

### tb/volume_trilinear_sampler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume trilinear sampler testbench
// Streams voxel writes and sample queries into the sampler under several volume
// sizes, predicts every result (an exact integer trilinear blend for interior
// samples), and compares each output transfer field by field, with random
// idling on both streams and one long output back-pressure stretch.
// ----------------------------------------------------------------------------
module volume_trilinear_sampler_test;
	import vts_pkg::*;

	localparam int  DRAIN_CYCLES = 24;
	localparam int  HOLD_CYCLES  = 400;
	localparam int  CYCLE_LIMIT  = 600000;
	localparam int  PHASE_ITEMS  = 110;
	localparam int  COORD_MAX    = (1 << COORD_BITS) - 1;
	localparam int  FRAC_MASK    = (1 << FRAC_BITS) - 1;
	// Unassigned register index; writes to it must leave the sizes alone.
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

	typedef struct {
		logic                         op;
		logic [ADDR_BITS-1:0]         vidx;
		logic signed [VALUE_BITS-1:0] vval;
		logic [COORD_BITS-1:0]        px;
		logic [COORD_BITS-1:0]        py;
		logic [COORD_BITS-1:0]        pz;
	} voxel_req_t;

	typedef struct {
		logic signed [VALUE_BITS-1:0] value;
		logic                         fallback;
		logic                         outside;
	} sample_res_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
	logic [SIZE_BITS-1:0]      cfg_data  = '0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [IN_TDATA_BITS-1:0]  s_tdata   = '0;
	logic [0:0]                s_tuser   = '0;
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic [1:0]                m_tuser;

	volume_trilinear_sampler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	voxel_req_t                   pending_reqs[$];
	sample_res_t                  expected_samples[$];
	voxel_req_t                   cur_req;
	logic signed [VALUE_BITS-1:0] voxel_mem [0:(1 << ADDR_BITS) - 1];
	bit                           voxel_known [0:(1 << ADDR_BITS) - 1];
	logic [SIZE_BITS-1:0]         cfg_size [0:2] = '{SIZE_MAX, SIZE_MAX, SIZE_MAX};
	logic                         steady = 1'b0;
	int                           gap_left, stall_left, hold_left, in_count, cycle_count;
	logic                         hold_done;
	int                           errors, n_writes, n_interior, n_fallback, n_outside, n_settings;

	function automatic int eff_size(input logic [SIZE_BITS-1:0] r);
		return (r > SIZE_MAX) ? int'(SIZE_MAX) : int'(r);
	endfunction

	function automatic int voxel_addr(input int x, input int y, input int z);
		int xs, ys;
		xs = eff_size(cfg_size[REG_X_SIZE]);
		ys = eff_size(cfg_size[REG_Y_SIZE]);
		return x + y * xs + z * xs * ys;
	endfunction

	// Mostly short gaps, a few long ones; none at all in steady phases.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady)
			return 0;
		else if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 40);
	endfunction

	// Applies one accepted input transfer to the volume copy and queues the
	// sample it produces, if any.
	task automatic predict_transfer(input voxel_req_t r);
		int xs, ys, zs, cx, cy, cz, fx, fy, fz, wx, wy, wz;
		longint acc, q;
		sample_res_t res;
		if (r.op == OP_WRITE) begin
			voxel_mem[r.vidx] = r.vval;
			n_writes++;
		end else begin
			xs = eff_size(cfg_size[REG_X_SIZE]);
			ys = eff_size(cfg_size[REG_Y_SIZE]);
			zs = eff_size(cfg_size[REG_Z_SIZE]);
			cx = int'(r.px) >> FRAC_BITS;
			cy = int'(r.py) >> FRAC_BITS;
			cz = int'(r.pz) >> FRAC_BITS;
			fx = int'(r.px) & FRAC_MASK;
			fy = int'(r.py) & FRAC_MASK;
			fz = int'(r.pz) & FRAC_MASK;
			res.value = '0;
			res.fallback = 1'b0;
			res.outside = 1'b0;
			if (cx >= xs || cy >= ys || cz >= zs) begin
				res.outside = 1'b1;
				n_outside++;
			end else if (cx + 1 >= xs || cy + 1 >= ys || cz + 1 >= zs) begin
				res.value = voxel_mem[voxel_addr(cx, cy, cz)];
				res.fallback = 1'b1;
				n_fallback++;
			end else begin
				// Exact weighted sum over 2^(3*FRAC_BITS), then truncation toward zero.
				acc = 0;
				for (int i = 0; i < 8; i++) begin
					wx = (i & 1) ? fx : (1 << FRAC_BITS) - fx;
					wy = (i & 2) ? fy : (1 << FRAC_BITS) - fy;
					wz = (i & 4) ? fz : (1 << FRAC_BITS) - fz;
					acc += longint'(voxel_mem[voxel_addr(cx + (i & 1), cy + ((i >> 1) & 1),
						cz + ((i >> 2) & 1))]) * wx * wy * wz;
				end
				q = (acc < 0) ? -((-acc) >>> (3 * FRAC_BITS)) : (acc >>> (3 * FRAC_BITS));
				res.value = q[VALUE_BITS-1:0];
				n_interior++;
			end
			expected_samples.push_back(res);
		end
	endtask

	task automatic check_result(input logic signed [VALUE_BITS-1:0] got_v,
			input logic got_fb, input logic got_out);
		sample_res_t want;
		if (expected_samples.size() == 0) begin
			errors++;
			$display("%0t: result with nothing expected: sample %0d fallback %0b outside %0b",
				$time, got_v, got_fb, got_out);
		end else begin
			want = expected_samples.pop_front();
			if (got_v !== want.value) begin
				errors++;
				$display("%0t: sample mismatch: expected %0d, actual %0d", $time, want.value, got_v);
			end
			if (got_fb !== want.fallback) begin
				errors++;
				$display("%0t: edge_fallback mismatch: expected %0b, actual %0b",
					$time, want.fallback, got_fb);
			end
			if (got_out !== want.outside) begin
				errors++;
				$display("%0t: out_of_range mismatch: expected %0b, actual %0b",
					$time, want.outside, got_out);
			end
		end
	endtask

	// Input driver: presents queued items, predicts each one on its transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			gap_left <= 0;
			in_count <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_transfer(cur_req);
				in_count <= in_count + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0 || pending_reqs.size() == 0) begin
					s_tvalid <= 1'b0;
					if (gap_left != 0)
						gap_left <= gap_left - 1;
				end else begin
					cur_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= IN_TDATA_BITS'({cur_req.pz, cur_req.py, cur_req.px,
						cur_req.vval, cur_req.vidx});
					s_tuser <= cur_req.op;
					gap_left <= pick_gap();
				end
			end
		end
	end

	// One long output hold-off once the input side is busy, so the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && in_count >= 200 && s_tvalid) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Output monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result($signed(m_tdata[VALUE_BITS-1:0]), m_tuser[0], m_tuser[1]);
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d items queued and %0d samples outstanding",
				$time, pending_reqs.size(), expected_samples.size());
			$display("** volume_trilinear_sampler: FAILED **");
			$finish;
		end
	end

	task automatic push_write(input int a, input logic [VALUE_BITS-1:0] v);
		voxel_req_t r;
		r.op = OP_WRITE;
		r.vidx = a[ADDR_BITS-1:0];
		r.vval = v;
		r.px = COORD_BITS'($urandom);
		r.py = COORD_BITS'($urandom);
		r.pz = COORD_BITS'($urandom);
		voxel_known[r.vidx] = 1'b1;
		pending_reqs.push_back(r);
	endtask

	task automatic need_voxel(input int a);
		if (!voxel_known[a])
			push_write(a, VALUE_BITS'($urandom));
	endtask

	// Queues a sample query, preceded by writes to any voxel it would read
	// that has never been stored.
	task automatic push_sample(input int px, input int py, input int pz);
		voxel_req_t r;
		int xs, ys, zs, cx, cy, cz;
		xs = eff_size(cfg_size[REG_X_SIZE]);
		ys = eff_size(cfg_size[REG_Y_SIZE]);
		zs = eff_size(cfg_size[REG_Z_SIZE]);
		cx = px >> FRAC_BITS;
		cy = py >> FRAC_BITS;
		cz = pz >> FRAC_BITS;
		if (cx < xs && cy < ys && cz < zs) begin
			if (cx + 1 >= xs || cy + 1 >= ys || cz + 1 >= zs)
				need_voxel(voxel_addr(cx, cy, cz));
			else
				for (int i = 0; i < 8; i++)
					need_voxel(voxel_addr(cx + (i & 1), cy + ((i >> 1) & 1), cz + ((i >> 2) & 1)));
		end
		r.op = OP_SAMPLE;
		r.vidx = ADDR_BITS'($urandom);
		r.vval = VALUE_BITS'($urandom);
		r.px = COORD_BITS'(px);
		r.py = COORD_BITS'(py);
		r.pz = COORD_BITS'(pz);
		pending_reqs.push_back(r);
	endtask

	function automatic int rand_coord(input int s);
		int r, top;
		r = $urandom_range(0, 99);
		top = (s + 1) * (1 << FRAC_BITS) - 1;
		if (top > COORD_MAX)
			top = COORD_MAX;
		if (r < 10)
			return $urandom_range(0, COORD_MAX);
		else if (r < 30 && s >= 2)
			return ((s - 1 - $urandom_range(0, 1)) << FRAC_BITS) | $urandom_range(0, FRAC_MASK);
		else
			return $urandom_range(0, top);
	endfunction

	function automatic logic [SIZE_BITS-1:0] rand_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return SIZE_BITS'($urandom_range(1, 5));
		else if (r < 75)
			return SIZE_BITS'($urandom_range(1, 32));
		else if (r < 85)
			return SIZE_MAX;
		else if (r < 92)
			return '0;
		else
			return SIZE_BITS'($urandom_range(33, 63));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [SIZE_BITS-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= REG_Z_SIZE)
			cfg_size[idx] = v;
	endtask

	task automatic set_sizes(input logic [SIZE_BITS-1:0] xs, input logic [SIZE_BITS-1:0] ys,
			input logic [SIZE_BITS-1:0] zs);
		write_reg(REG_X_SIZE, xs);
		write_reg(REG_Y_SIZE, ys);
		write_reg(REG_Z_SIZE, zs);
		n_settings++;
		@(negedge clk);
	endtask

	// Waits until every queued item has gone and every sample has come back,
	// then lets the pipeline run dry before the configuration is touched.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_samples.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int r, xs, ys, zs, vol;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		n_settings = 1;
		@(negedge clk);

		// Full-size volume after reset: value extremes around the origin and at
		// the far corner, exact and mixed weights, far-face fallback.
		for (int i = 0; i < 8; i++)
			push_write(voxel_addr(i & 1, (i >> 1) & 1, (i >> 2) & 1),
				(i % 3 == 0) ? 16'h7FFF : 16'h8000);
		push_write(voxel_addr(MAX_DIM - 1, MAX_DIM - 1, MAX_DIM - 1), 16'h8000);
		push_sample(0, 0, 0);
		push_sample(FRAC_MASK, FRAC_MASK, FRAC_MASK);
		push_sample(128, 0, FRAC_MASK);
		push_sample(COORD_MAX, COORD_MAX, COORD_MAX);
		push_sample(30 * 256 + FRAC_MASK, 30 * 256 + FRAC_MASK, 30 * 256 + 1);
		push_sample(31 * 256, 0, 0);
		wait_idle();

		// Smallest volume with an interior: one interior cell, a face, and beyond.
		set_sizes(SIZE_BITS'(2), SIZE_BITS'(2), SIZE_BITS'(2));
		push_sample(FRAC_MASK, 128, 1);
		push_sample(256, 0, 0);
		push_sample(512, 0, 0);
		push_sample(0, 0, 3 * 256 - 1);
		wait_idle();

		// Empty volume along x: everything is out of range. The spare index is
		// written with all ones and must change nothing.
		set_sizes(SIZE_BITS'(0), SIZE_BITS'(5), SIZE_BITS'(7));
		write_reg(REG_SPARE, '1);
		@(negedge clk);
		push_sample(0, 0, 0);
		push_sample(COORD_MAX, COORD_MAX, COORD_MAX);
		wait_idle();

		// Oversized settings clamp to the largest volume.
		set_sizes(SIZE_BITS'(63), SIZE_BITS'(40), SIZE_BITS'(33));
		push_sample(COORD_MAX, COORD_MAX, COORD_MAX);
		push_sample(30 * 256 + 1, 0, 5);
		wait_idle();

		// Single voxel: the corner always falls back.
		set_sizes(SIZE_BITS'(1), SIZE_BITS'(1), SIZE_BITS'(1));
		push_sample(0, 0, 0);
		push_sample(256, 0, 0);
		push_sample(FRAC_MASK, FRAC_MASK, FRAC_MASK);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			set_sizes(rand_size(), rand_size(), rand_size());
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_SPARE, SIZE_BITS'($urandom));
				@(negedge clk);
			end
			steady = (p == 3);
			xs = eff_size(cfg_size[REG_X_SIZE]);
			ys = eff_size(cfg_size[REG_Y_SIZE]);
			zs = eff_size(cfg_size[REG_Z_SIZE]);
			vol = xs * ys * zs;
			while (pending_reqs.size() < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					push_sample(rand_coord(xs), rand_coord(ys), rand_coord(zs));
				else if (r < 85 || vol == 0)
					push_write($urandom_range(0, (1 << ADDR_BITS) - 1), VALUE_BITS'($urandom));
				else
					push_write($urandom_range(0, vol - 1), VALUE_BITS'($urandom));
			end
			wait_idle();
		end

		if (expected_samples.size() != 0) begin
			errors++;
			$display("%0t: %0d samples never arrived", $time, expected_samples.size());
		end
		$display("Run covered %0d voxel writes and %0d samples over %0d volume size settings:",
			n_writes, n_interior + n_fallback + n_outside, n_settings);
		$display("%0d interpolated, %0d edge fallbacks, %0d out of range; %0d mismatches.",
			n_interior, n_fallback, n_outside, errors);
		if (errors == 0)
			$display("** volume_trilinear_sampler: PASSED **");
		else
			$display("** volume_trilinear_sampler: FAILED **");
		$finish;
	end

endmodule
